// ===== hdl/hsfc_pkg.sv =====
// Package for the half/single float converter.
// Holds mode codes and the two conversion functions; no dependencies.
package hsfc_pkg;

    typedef enum logic {
        MODE_NARROW = 1'b0,
        MODE_WIDEN  = 1'b1
    } mode_t;

    localparam logic [14:0] HALF_INF  = 15'h7c00;
    localparam logic [14:0] HALF_QNAN = 15'h7e00;
    localparam logic [30:0] SGL_INF   = 31'h7f800000;
    localparam logic [30:0] SGL_QNAN  = 31'h7fc00000;

    // Narrow binary32 to binary16, round to nearest even
    function automatic logic [15:0] narrow(input logic [31:0] x);
        logic        sign;
        logic [7:0]  e;
        logic [22:0] frac;
        logic [10:0] hm;
        logic [12:0] rem;
        logic [15:0] r;
        logic [23:0] sig;
        logic [4:0]  sh;
        logic [23:0] shifted;
        logic [23:0] mask;
        logic [23:0] halfv;
        logic [23:0] remw;
        logic [14:0] mag;
        begin
            sign = x[31];
            e    = x[30:23];
            frac = x[22:0];
            sig  = {1'b1, frac};
            sh   = 5'(8'd126 - e);
            shifted = sig >> sh;
            mask    = (24'd1 << sh) - 24'd1;
            halfv   = 24'd1 << (sh - 5'd1);
            remw    = sig & mask;
            hm   = {1'b0, frac[22:13]};
            rem  = frac[12:0];
            if (e == 8'hff)
                r = {sign, (frac == 23'd0) ? HALF_INF : HALF_QNAN};
            else if (e > 8'd142)
                r = {sign, HALF_INF};
            else if (e >= 8'd113)
            begin
                // Rounding carry propagates into the exponent; 0x7c00 is infinity
                mag = {5'(e - 8'd112), 10'd0} + {4'd0, hm};
                if (rem > 13'h1000 || (rem == 13'h1000 && hm[0]))
                    mag = mag + 15'd1;
                r = {sign, mag};
            end
            else if (e < 8'd102)
                r = {sign, 15'd0};
            else
            begin
                mag = {4'd0, shifted[10:0]};
                if (remw > halfv || (remw == halfv && shifted[0]))
                    mag = mag + 15'd1;
                r = {sign, mag};
            end
            return r;
        end
    endfunction

    // Widen binary16 to binary32 exactly
    function automatic logic [31:0] widen(input logic [15:0] h);
        logic        sign;
        logic [4:0]  e;
        logic [9:0]  m;
        logic [3:0]  p;
        logic [31:0] r;
        logic [22:0] mm;
        begin
            sign = h[15];
            e    = h[14:10];
            m    = h[9:0];
            p    = 4'd0;
            for (int i = 0; i < 10; i++)
                if (m[i])
                    p = 4'(i);
            mm = 23'({13'd0, m} << (5'd23 - {1'b0, p}));
            if (e == 5'h1f)
                r = {sign, (m == 10'd0) ? SGL_INF : SGL_QNAN};
            else if (e != 5'd0)
                r = {sign, 8'({3'd0, e} + 8'd112), m, 13'd0};
            else if (m == 10'd0)
                r = {sign, 31'd0};
            else
                r = {sign, 8'({4'd0, p} + 8'd103), mm};
            return r;
        end
    endfunction

endpackage

// ===== hdl/hsfc_core.sv =====
// Conversion datapath between input and result registers.
// Depends on hsfc_pkg.
module hsfc_core
(
    input  logic        mode,
    input  logic [31:0] operand_bits,
    output logic [31:0] result_bits
);
    // Select direction
    always_comb
    begin
        if (hsfc_pkg::mode_t'(mode) == hsfc_pkg::MODE_WIDEN)
            result_bits = hsfc_pkg::widen(operand_bits[15:0]);
        else
            result_bits = {16'd0, hsfc_pkg::narrow(operand_bits)};
    end
endmodule

// ===== hdl/half_single_float_convert.sv =====
// Half/single float converter: one transaction per cycle while the output is
// not stalled, through the input register, then the result register; a stall on the output
// holds both registers only once the result register is full.
// Depends on hsfc_pkg and hsfc_core.
module half_single_float_convert
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [31:0] operand_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result_bits
);
    logic        a_valid_reg;
    logic        a_mode_reg;
    logic [31:0] a_bits_reg;
    logic        b_valid_reg;
    logic [31:0] b_bits_reg;
    logic [31:0] conv;
    logic        b_load;
    logic        a_load;

    hsfc_core u_core
    (
        .mode         (a_mode_reg),
        .operand_bits (a_bits_reg),
        .result_bits  (conv)
    );

    assign b_load   = !b_valid_reg || !out_stall;
    assign a_load   = !a_valid_reg || b_load;
    assign in_stall = !a_load;
    assign out_valid   = b_valid_reg;
    assign result_bits = b_bits_reg;

    // Advance the two stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_load)
                a_valid_reg <= in_valid;
            if (b_load)
                b_valid_reg <= a_valid_reg;
        end
    end

    // Hold payloads
    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_mode_reg <= mode;
            a_bits_reg <= operand_bits;
        end
        if (b_load)
            b_bits_reg <= conv;
    end
endmodule

// ===== tb/hsfc_checker.sv =====
// Checker for the half/single float converter: watches both channels,
// predicts each result from the accepted operand and compares in order.
// Depends on hsfc_pkg for the mode codes.
`timescale 1ns / 1ps

module hsfc_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        mode,
    input  logic [31:0] operand_bits,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] result_bits,
    output int          fail_count,
    output int          pending_count,
    output int          result_count
);

    logic [31:0] expected_results[$];

    // Narrow binary32 to binary16, round to nearest even
    function automatic logic [31:0] predict_half(input logic [31:0] x);
        logic [15:0] sgn;
        logic [7:0]  ex;
        logic [22:0] fr;
        logic [31:0] hexp;
        logic [31:0] hman;
        logic [31:0] rm;
        logic [31:0] sg;
        logic [31:0] sh;
        logic [31:0] hf;
        begin
            sgn = {x[31], 15'd0};
            ex  = x[30:23];
            fr  = x[22:0];
            if (ex == 8'hff)
                return {16'd0, sgn | ((fr == 0) ? 16'h7c00 : 16'h7e00)};
            if (ex > 8'd142)
                return {16'd0, sgn | 16'h7c00};
            if (ex >= 8'd113)
            begin
                hexp = ex - 112;
                hman = fr >> 13;
                rm   = fr & 32'h1fff;
                if (rm > 32'h1000 || (rm == 32'h1000 && hman[0]))
                begin
                    hman++;
                    if (hman == 32'h400)
                    begin
                        hman = 0;
                        hexp++;
                        if (hexp >= 31)
                            return {16'd0, sgn | 16'h7c00};
                    end
                end
                return {16'd0, sgn | 16'((hexp << 10) | hman)};
            end
            if (ex < 8'd102)
                return {16'd0, sgn};
            sg   = 32'h800000 | fr;
            sh   = 126 - ex;
            hman = sg >> sh;
            rm   = sg & ((32'd1 << sh) - 1);
            hf   = 32'd1 << (sh - 1);
            if (rm > hf || (rm == hf && hman[0]))
                hman++;
            return {16'd0, sgn | 16'(hman)};
        end
    endfunction

    // Widen binary16 to binary32 exactly
    function automatic logic [31:0] predict_single(input logic [15:0] h);
        logic [31:0] sgn;
        logic [4:0]  ex;
        logic [9:0]  mn;
        int          lead;
        begin
            sgn = {h[15], 31'd0};
            ex  = h[14:10];
            mn  = h[9:0];
            if (ex == 5'h1f)
                return sgn | ((mn == 0) ? 32'h7f800000 : 32'h7fc00000);
            if (ex != 0)
                return sgn | ((32'(ex) + 112) << 23) | (32'(mn) << 13);
            if (mn == 0)
                return sgn;
            lead = 9;
            while (!mn[lead])
                lead--;
            return sgn | ((32'(lead) + 103) << 23) | ((32'(mn) << (23 - lead)) & 32'h7fffff);
        end
    endfunction

    assign pending_count = expected_results.size();

    // Predict on each accepted input, compare on each accepted output
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count   <= 0;
            result_count <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (mode == hsfc_pkg::MODE_NARROW)
                    expected_results.push_back(predict_half(operand_bits));
                else
                    expected_results.push_back(predict_single(operand_bits[15:0]));
            end
            if (out_valid && !out_stall)
            begin
                result_count <= result_count + 1;
                if (expected_results.size() == 0)
                begin
                    $error("result_bits: no transaction expected, actual %h", result_bits);
                    fail_count <= fail_count + 1;
                end
                else if (expected_results[0] !== result_bits)
                begin
                    $error("result_bits: expected %h, actual %h",
                           expected_results[0], result_bits);
                    fail_count <= fail_count + 1;
                    void'(expected_results.pop_front());
                end
                else
                    void'(expected_results.pop_front());
            end
        end
    end

endmodule

// ===== tb/tb_half_single_float_convert.sv =====
// Top of the testbench: drives operands into the converter with random gaps
// and stalls; depends on hsfc_pkg, the converter and hsfc_checker.
`timescale 1ns / 1ps

module tb_half_single_float_convert;

    localparam int RANDOM_ITEMS = 1600;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        mode;
    logic [31:0] operand_bits;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] result_bits;
    int          fail_count;
    int          pending_count;
    int          result_count;
    bit          steady;

    logic [32:0] directed[$] = '{
        {hsfc_pkg::MODE_NARROW, 32'h00000000}, {hsfc_pkg::MODE_NARROW, 32'h80000000},
        {hsfc_pkg::MODE_NARROW, 32'h7f800000}, {hsfc_pkg::MODE_NARROW, 32'hff800000},
        {hsfc_pkg::MODE_NARROW, 32'h7f800001}, {hsfc_pkg::MODE_NARROW, 32'hffffffff},
        {hsfc_pkg::MODE_NARROW, 32'h477fe000}, {hsfc_pkg::MODE_NARROW, 32'h477ff000},
        {hsfc_pkg::MODE_NARROW, 32'h47800000}, {hsfc_pkg::MODE_NARROW, 32'h33000000},
        {hsfc_pkg::MODE_NARROW, 32'h33000001}, {hsfc_pkg::MODE_NARROW, 32'h007fffff},
        {hsfc_pkg::MODE_NARROW, 32'h387fe000}, {hsfc_pkg::MODE_NARROW, 32'h387ff000},
        {hsfc_pkg::MODE_NARROW, 32'h3f801000}, {hsfc_pkg::MODE_NARROW, 32'h3f803000},
        {hsfc_pkg::MODE_NARROW, 32'h3f801001}, {hsfc_pkg::MODE_WIDEN, 32'h00000000},
        {hsfc_pkg::MODE_WIDEN, 32'hffff8000}, {hsfc_pkg::MODE_WIDEN, 32'h00007c00},
        {hsfc_pkg::MODE_WIDEN, 32'h0000fc00}, {hsfc_pkg::MODE_WIDEN, 32'h12347e01},
        {hsfc_pkg::MODE_WIDEN, 32'h00000001}, {hsfc_pkg::MODE_WIDEN, 32'h000003ff},
        {hsfc_pkg::MODE_WIDEN, 32'habcd7bff}
    };

    half_single_float_convert dut (.*);

    hsfc_checker checker_i (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Output stall, with a long stretch of none in the middle
    always @(posedge clk)
        out_stall <= !steady && ($urandom_range(99) < 33);

    function automatic logic [32:0] random_operand();
        logic [31:0] v;
        begin
            v = $urandom;
            // Steer the exponent or low mantissa bits towards rounding, underflow and special-value boundaries
            case ($urandom_range(5))
                0: v[30:23] = 8'd101 + 8'($urandom_range(13));
                1: v[30:23] = 8'd140 + 8'($urandom_range(3));
                2: v[30:23] = $urandom_range(1) ? 8'hff : 8'h00;
                3: v[12:0]  = 13'h1000;
                4: v[14:10] = $urandom_range(1) ? 5'h1f : 5'h00;
                default: ;
            endcase
            return {1'($urandom_range(1)), v};
        end
    endfunction

    task automatic send_operand(input logic [32:0] item);
        begin
            while ($urandom_range(99) < 33 && !steady)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid     <= 1'b1;
            mode         <= item[32];
            operand_bits <= item[31:0];
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        mode         = hsfc_pkg::MODE_NARROW;
        operand_bits = '0;
        steady       = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_operand(directed[i]);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady <= (n >= 600 && n < 800);
            send_operand(random_operand());
        end
        in_valid <= 1'b0;
        steady   <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Converted %0d operands in both directions, directed edges and random.",
                 result_count);
        if (fail_count == 0)
            $display("tb_half_single_float_convert: clean");
        else
            $display("tb_half_single_float_convert: errors");
        $finish;
    end

    // Hard stop on a hung handshake
    initial
    begin
        #2000000;
        $display("tb_half_single_float_convert: errors");
        $finish;
    end

endmodule
